// ----- rtl/core/lkv_pkg.sv -----
// lkv_pkg: sizes, payload and control structs of the LRU key-value cache.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;

    // entry index and recency age share a width (ages run 0..MAX_ENTRIES-1)
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AGE_W = IDX_W;

    // capacity register and the effective capacity derived from it
    localparam int CAP_W       = 5;
    localparam int CAP_RESET   = 16;
    localparam int CNT_MIN_W   = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W       = (CNT_MIN_W > CAP_W) ? CNT_MIN_W : CAP_W;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic                  hit;
        logic [VALUE_BITS-1:0] read_value;
    } rsp_t;

endpackage

// ----- rtl/core/lkv_req_if.sv -----
// lkv_req_if: request channel (get/put word) of the LRU key-value cache.
// Depends on lkv_pkg for field widths.
`timescale 1ns / 1ps

interface lkv_req_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    req_type;
    logic signed [lkv_pkg::KEY_BITS-1:0]     key;
    logic signed [lkv_pkg::VALUE_BITS-1:0]   value;

    modport source (output valid, output req_type, output key, output value, input ready);
    modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

// ----- rtl/core/lkv_rsp_if.sv -----
// lkv_rsp_if: result channel (hit flag and read value) of the LRU key-value cache.
// Depends on lkv_pkg for field widths.
`timescale 1ns / 1ps

interface lkv_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    hit;
    logic signed [lkv_pkg::VALUE_BITS-1:0]   read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ----- rtl/core/lkv_cfg_if.sv -----
// lkv_cfg_if: capacity register write channel of the LRU key-value cache.
// Depends on lkv_pkg for the register width.
`timescale 1ns / 1ps

interface lkv_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lkv_pkg::CAP_W-1:0]     capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ----- rtl/core/lru_key_value_cache.sv -----
// lru_key_value_cache: top level - capacity register, result register, core wiring.
// Depends on lkv_pkg, lkv_req_if, lkv_rsp_if, lkv_cfg_if, lkv_store, lkv_ctrl.
`timescale 1ns / 1ps

// channel | dir | handshake     | word
// --------+-----+---------------+-------------------------------------------
// req     | in  | valid / ready | req_type (0 get, 1 put), key, value
// rsp     | out | valid / ready | hit, read_value (0 on miss and on put)
// cfg     | in  | valid / ready | capacity (0 acts as 1, above 16 acts as 16)
//
// One request at a time. The keys are scanned out of the key/value memory one
// entry per cycle through its single read port; a hit ends the scan at the
// matching entry, a miss scans all MAX_ENTRIES entries.
// Recency ages and valid bits sit in flops and update in the final cycle.
// Reset empties the cache at once (valid bits clear) and sets capacity to 16.
// The result register lets a new request be taken while a result waits; a
// request only stalls in its final cycle while that register is still full.

module lru_key_value_cache (
    input logic       clk,
    input logic       rst_n,
    lkv_req_if.sink   req,
    lkv_rsp_if.source rsp,
    lkv_cfg_if.sink   cfg
);
    import lkv_pkg::*;

    logic [CAP_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      cap_ext;
    logic [CNT_W-1:0]      eff_cap;

    logic                  out_valid_reg;
    rsp_t                  out_data_reg;
    logic                  rsp_free;

    logic                  rsp_load;
    rsp_t                  rsp_data;
    mem_rd_t               mem_rd;
    mem_wr_t               mem_wr;
    entry_t                mem_rdata;

    // capacity register: always writable; the core uses its current value when a put commits
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_W'(CAP_RESET);
        end
        else if (cfg.valid)
        begin
            cap_reg <= cfg.capacity;
        end
    end

    // clamp capacity into 1..MAX_ENTRIES
    assign cap_ext = CNT_W'(cap_reg);
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (cap_ext > CNT_W'(MAX_ENTRIES))
        begin
            eff_cap = CNT_W'(MAX_ENTRIES);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    // result register: frees in the same cycle the consumer takes it
    assign rsp_free = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rsp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            out_data_reg <= rsp_data;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_data_reg.hit;
    assign rsp.read_value = out_data_reg.read_value;

    lkv_store u_store (
        .clk   (clk),
        .rd    (mem_rd),
        .wr    (mem_wr),
        .rdata (mem_rdata)
    );

    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_type  (req.req_type),
        .req_key   (req.key),
        .req_value (req.value),
        .eff_cap   (eff_cap),
        .rsp_free  (rsp_free),
        .rsp_load  (rsp_load),
        .rsp_data  (rsp_data),
        .mem_rd    (mem_rd),
        .mem_rdata (mem_rdata),
        .mem_wr    (mem_wr)
    );

endmodule

// ----- rtl/core/lkv_store.sv -----
// lkv_store: key/value memory, one write port and one registered read port.
// Depends on lkv_pkg (entry and port structs).
`timescale 1ns / 1ps

module lkv_store (
    input  logic             clk,
    input  lkv_pkg::mem_rd_t rd,
    input  lkv_pkg::mem_wr_t wr,
    output lkv_pkg::entry_t  rdata
);
    import lkv_pkg::*;

    entry_t mem [MAX_ENTRIES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/lkv_ctrl.sv -----
// lkv_ctrl: request sequencer - key scan over the store, recency ages, replacement.
// Depends on lkv_pkg; drives the ports of lkv_store.
`timescale 1ns / 1ps

module lkv_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic                               req_type,
    input  logic [lkv_pkg::KEY_BITS-1:0]       req_key,
    input  logic [lkv_pkg::VALUE_BITS-1:0]     req_value,
    input  logic [lkv_pkg::CNT_W-1:0]          eff_cap,
    input  logic                               rsp_free,
    output logic                               rsp_load,
    output lkv_pkg::rsp_t                      rsp_data,
    output lkv_pkg::mem_rd_t                   mem_rd,
    input  lkv_pkg::entry_t                    mem_rdata,
    output lkv_pkg::mem_wr_t                   mem_wr
);
    import lkv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                  state_reg;
    logic [IDX_W-1:0]        rd_ptr_reg;
    logic                    pend_reg;
    logic [IDX_W-1:0]        pend_idx_reg;
    logic                    found_reg;
    logic [MAX_ENTRIES-1:0]  valid_reg;
    logic [MAX_ENTRIES-1:0]  valid_next;

    logic                    is_put_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    logic [IDX_W-1:0]        found_idx_reg;
    logic [AGE_W-1:0]        found_age_reg;
    logic [VALUE_BITS-1:0]   found_val_reg;
    logic [AGE_W-1:0]        age_reg  [MAX_ENTRIES];
    logic [AGE_W-1:0]        age_next [MAX_ENTRIES];

    logic                    match;
    logic                    last;
    logic                    commit;
    logic [IDX_W-1:0]        rd_ptr_next;
    logic [MAX_ENTRIES-1:0]  evict;
    logic [IDX_W-1:0]        free_idx;

    assign req_ready = (state_reg == S_IDLE);
    assign match     = pend_reg && valid_reg[pend_idx_reg] && (mem_rdata.key == key_reg);
    assign last      = pend_reg && (pend_idx_reg == IDX_W'(MAX_ENTRIES - 1));
    assign commit    = (state_reg == S_DONE) && rsp_free;
    assign rd_ptr_next = (rd_ptr_reg == IDX_W'(MAX_ENTRIES - 1)) ? '0 : rd_ptr_reg + 1'b1;

    assign mem_rd.en   = (state_reg == S_SCAN);
    assign mem_rd.addr = rd_ptr_reg;

    assign rsp_load            = commit;
    assign rsp_data.hit        = found_reg;
    assign rsp_data.read_value = (found_reg && !is_put_reg) ? found_val_reg : '0;

    // ages of valid entries are dense 0..n-1, so evicting oldest until below
    // capacity drops every entry aged cap-1 or more
    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            evict[i] = valid_reg[i] && (CNT_W'(age_reg[i]) >= (eff_cap - CNT_W'(1)));
            if (!valid_reg[i] || evict[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign mem_wr.en         = commit && is_put_reg;
    assign mem_wr.addr       = found_reg ? found_idx_reg : free_idx;
    assign mem_wr.data.key   = key_reg;
    assign mem_wr.data.value = value_reg;

    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i];
            age_next[i]   = age_reg[i];
            if (commit && found_reg)
            begin
                if (valid_reg[i] && (age_reg[i] < found_age_reg))
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
                if (IDX_W'(i) == found_idx_reg)
                begin
                    age_next[i] = '0;
                end
            end
            else if (commit && is_put_reg)
            begin
                if (evict[i])
                begin
                    valid_next[i] = 1'b0;
                end
                else if (valid_reg[i])
                begin
                    age_next[i] = age_reg[i] + 1'b1;
                end
                if (IDX_W'(i) == free_idx)
                begin
                    valid_next[i] = 1'b1;
                    age_next[i]   = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_ptr_reg   <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            found_reg    <= 1'b0;
            valid_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg  <= S_SCAN;
                        rd_ptr_reg <= '0;
                        pend_reg   <= 1'b0;
                        found_reg  <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    rd_ptr_reg   <= rd_ptr_next;
                    pend_reg     <= 1'b1;
                    pend_idx_reg <= rd_ptr_reg;
                    if (match)
                    begin
                        found_reg <= 1'b1;
                        pend_reg  <= 1'b0;
                        state_reg <= S_DONE;
                    end
                    else if (last)
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (rsp_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg <= age_next;
        if (state_reg == S_IDLE && req_valid)
        begin
            is_put_reg <= req_type;
            key_reg    <= req_key;
            value_reg  <= req_value;
        end
        if (state_reg == S_SCAN && match)
        begin
            found_idx_reg <= pend_idx_reg;
            found_age_reg <= age_reg[pend_idx_reg];
            found_val_reg <= mem_rdata.value;
        end
    end

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for lru_key_value_cache. It drives get/put and capacity words
// and checks every result word against an LRU cache model kept inside the bench.
// Depends on lkv_pkg, the lkv_req_if / lkv_rsp_if / lkv_cfg_if interfaces and the RTL.
`timescale 1ns / 1ps

module tb;
    import lkv_pkg::*;

    // request opcodes on req_type
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // A miss scans every entry, and result back-pressure can stretch a request.
    // About 1460 words; even with the longest gap and the longest stall on every
    // word the run stays far inside this limit.
    localparam int CYCLE_LIMIT = 1000000;
    // quiet window after the last result, to catch stray words
    localparam int TAIL_CYCLES = 2 * (MAX_ENTRIES + 4);

    typedef enum {STIM_REQ, STIM_CFG, STIM_SETTLE} stim_kind_t;

    typedef struct {
        stim_kind_t              kind;
        logic                    op;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
        logic [CAP_W-1:0]        cap;
        int unsigned             gap;   // idle cycles after this word is taken
    } stim_t;

    logic clk;
    logic rst_n;

    lkv_req_if req_ch ();
    lkv_rsp_if rsp_ch ();
    lkv_cfg_if cfg_ch ();

    lru_key_value_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Cache model: valid bits, keys, values, recency ages (0 = newest).
    // ------------------------------------------------------------------
    logic                  slot_used [MAX_ENTRIES];
    logic [KEY_BITS-1:0]   slot_key  [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] slot_val  [MAX_ENTRIES];
    int unsigned           slot_age  [MAX_ENTRIES];
    int unsigned           fill_count;
    logic [CAP_W-1:0]      cap_reg;

    stim_t stim_q[$];
    rsp_t  answers_due[$];

    int unsigned reqs_issued;
    int unsigned reqs_taken;
    int unsigned caps_issued;
    int unsigned caps_taken;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned error_count;
    int unsigned cycle_count;
    bit          sender_calm;

    function automatic int unsigned cap_in_force(logic [CAP_W-1:0] c);
        if (c == '0)
            return 1;
        if (c > MAX_ENTRIES)
            return MAX_ENTRIES;
        return c;
    endfunction

    function automatic int find_slot(logic [KEY_BITS-1:0] k);
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_used[i] && slot_key[i] == k)
                return i;
        return -1;
    endfunction

    // slot s becomes newest; everything newer than it ages by one
    function automatic void make_newest(int s);
        int unsigned a;
        a = slot_age[s];
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_used[i] && slot_age[i] < a)
                slot_age[i]++;
        slot_age[s] = 0;
    endfunction

    function automatic void drop_oldest();
        int oldest;
        oldest = -1;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest]))
                oldest = i;
        if (oldest >= 0)
        begin
            slot_used[oldest] = 1'b0;
            fill_count--;
        end
    endfunction

    // evicts until below capacity (also covers a capacity lowered under the
    // current fill), then places the key in the lowest free slot
    function automatic void insert_entry(logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
        int slot;
        slot = -1;
        while (fill_count >= cap_in_force(cap_reg) && fill_count > 0)
            drop_oldest();
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (!slot_used[i])
            begin
                if (slot < 0)
                    slot = i;
            end
            else
                slot_age[i]++;
        end
        slot_used[slot] = 1'b1;
        slot_key[slot]  = k;
        slot_val[slot]  = v;
        slot_age[slot]  = 0;
        fill_count++;
    endfunction

    function automatic rsp_t cache_access(logic op, logic [KEY_BITS-1:0] k,
                                          logic [VALUE_BITS-1:0] v);
        rsp_t r;
        int   s;
        s = find_slot(k);
        r.hit        = (s >= 0);
        r.read_value = '0;
        if (op == OP_GET)
        begin
            if (s >= 0)
            begin
                r.read_value = slot_val[s];
                make_newest(s);
            end
        end
        else if (s >= 0)
        begin
            slot_val[s] = v;
            make_newest(s);
        end
        else
            insert_entry(k, v);
        return r;
    endfunction

    // mostly back-to-back, some short gaps, the odd long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic push_req(input logic op, input logic [KEY_BITS-1:0] k,
                            input logic [VALUE_BITS-1:0] v);
        stim_t w;
        w.kind  = STIM_REQ;
        w.op    = op;
        w.key   = k;
        w.value = v;
        w.cap   = '0;
        w.gap   = sender_calm ? 0 : idle_len();
        stim_q.push_back(w);
    endtask

    // capacity words and settle marks both hold off until the cache is idle
    task automatic push_ctrl(input stim_kind_t kind, input logic [CAP_W-1:0] c);
        stim_t w;
        w.kind  = kind;
        w.op    = OP_GET;
        w.key   = '0;
        w.value = '0;
        w.cap   = c;
        w.gap   = 0;
        stim_q.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // Driver: all inputs move on the falling edge. A raised valid counts as
    // taken once the rising-edge monitor has bumped the matching counter.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_words
        logic req_v;
        logic cfg_v;
        bit   quiet;
        req_v = req_ch.valid;
        cfg_v = cfg_ch.valid;
        if (req_v && reqs_taken == reqs_issued)
            req_v = 1'b0;
        if (cfg_v && caps_taken == caps_issued)
            cfg_v = 1'b0;
        if (rst_n && !req_v && !cfg_v)
        begin
            quiet = (reqs_taken == reqs_issued) && (answers_due.size() == 0);
            if (gap_left > 0)
                gap_left--;
            else if (stim_q.size() > 0)
            begin
                case (stim_q[0].kind)
                    STIM_REQ:
                    begin
                        req_ch.req_type <= stim_q[0].op;
                        req_ch.key      <= stim_q[0].key;
                        req_ch.value    <= stim_q[0].value;
                        gap_left = stim_q[0].gap;
                        req_v = 1'b1;
                        reqs_issued++;
                        void'(stim_q.pop_front());
                    end
                    STIM_CFG:
                        if (quiet)
                        begin
                            cfg_ch.capacity <= stim_q[0].cap;
                            cfg_v = 1'b1;
                            caps_issued++;
                            void'(stim_q.pop_front());
                        end
                    default:
                        if (quiet)
                            void'(stim_q.pop_front());
                endcase
            end
        end
        req_ch.valid <= req_v;
        cfg_ch.valid <= cfg_v;
    end

    // result-side back-pressure, with stall-free stretches now and then
    always @(negedge clk)
    begin : drive_ready
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ((cycle_count % 3000) > 800 && $urandom_range(0, 99) < 20)
                stall_left = idle_len();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results are checked against the oldest prediction first, then
    // any accepted request or capacity word updates the model.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (answers_due.size() == 0)
                    report_mismatch("result word with nothing outstanding");
                else
                begin
                    want = answers_due.pop_front();
                    if (rsp_ch.hit !== want.hit)
                        report_mismatch($sformatf("hit %b, want %b", rsp_ch.hit, want.hit));
                    if (rsp_ch.read_value !== want.read_value)
                        report_mismatch($sformatf("read_value %h, want %h",
                                                  rsp_ch.read_value, want.read_value));
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                answers_due.push_back(cache_access(req_ch.req_type, req_ch.key, req_ch.value));
                reqs_taken++;
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                cap_reg = cfg_ch.capacity;
                caps_taken++;
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [KEY_BITS-1:0] key_pool [24];
        logic [CAP_W-1:0]    c;
        int unsigned         pool_n;
        int unsigned         phase_cap [6];
        logic [KEY_BITS-1:0] k;

        clk   = 1'b0;
        rst_n = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = OP_GET;
        req_ch.key      = '0;
        req_ch.value    = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = '0;
        rsp_ch.ready    = 1'b0;

        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_age[i]  = 0;
        end
        fill_count  = 0;
        cap_reg     = CAP_W'(CAP_RESET);
        reqs_issued = 0;
        reqs_taken  = 0;
        caps_issued = 0;
        caps_taken  = 0;
        gap_left    = 0;
        stall_left  = 0;
        error_count = 0;
        cycle_count = 0;
        sender_calm = 1'b0;

        // directed: empty miss, key/value extremes, put update, then capacity
        // lowered under the fill, capacity 0 acting as 1, capacity 1
        push_req(OP_GET, 32'h0000_0000, 32'h1234_5678);
        push_req(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
        push_req(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
        push_req(OP_PUT, 32'hffff_ffff, 32'h0000_0000);
        push_req(OP_PUT, 32'h0000_0000, 32'hffff_ffff);
        push_req(OP_GET, 32'h8000_0000, 32'h0);
        push_req(OP_GET, 32'h7fff_ffff, 32'h0);
        push_req(OP_GET, 32'h0000_0001, 32'h0);
        push_req(OP_PUT, 32'hffff_ffff, 32'd123);
        push_req(OP_GET, 32'hffff_ffff, 32'h0);
        push_ctrl(STIM_CFG, 5'd2);
        push_req(OP_PUT, 32'd5, 32'hdead_beef);
        push_req(OP_GET, 32'h8000_0000, 32'h0);
        push_req(OP_GET, 32'd5, 32'h0);
        push_ctrl(STIM_CFG, 5'd0);
        push_req(OP_PUT, 32'd6, 32'h0bad_cafe);
        push_req(OP_GET, 32'd5, 32'h0);
        push_req(OP_GET, 32'd6, 32'h0);
        push_ctrl(STIM_CFG, 5'd1);
        push_req(OP_PUT, 32'd7, 32'h5555_aaaa);
        push_req(OP_GET, 32'd6, 32'h0);

        // random: phases at different capacities, keys mostly from a pool a
        // little larger than the capacity so hits, updates and evictions mix
        phase_cap = '{31, 16, 17, 1, 0, 15};
        for (int i = 0; i < 24; i++)
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        for (int ph = 0; ph < 12; ph++)
        begin
            c = (ph < 6) ? CAP_W'(phase_cap[ph]) : CAP_W'($urandom_range(0, 31));
            push_ctrl(STIM_CFG, c);
            for (int i = 0; i < 24; i++)
                if ($urandom_range(0, 1) == 1)
                    key_pool[i] = $urandom;
            pool_n = cap_in_force(c) + $urandom_range(1, 6);
            if (pool_n > 24)
                pool_n = 24;
            sender_calm = (ph % 4 == 1);
            for (int n = 0; n < 120; n++)
            begin
                if (n == 60 && ph % 3 == 0)
                    push_ctrl(STIM_SETTLE, '0);
                k = ($urandom_range(0, 9) == 0) ? $urandom
                                                 : key_pool[$urandom_range(0, pool_n - 1)];
                push_req($urandom_range(0, 1) ? OP_PUT : OP_GET, k, $urandom);
            end
        end
        sender_calm = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(stim_q.size() == 0 && reqs_taken == reqs_issued && caps_taken == caps_issued
                 && answers_due.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (answers_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", answers_due.size()));
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/lkv_pkg.sv
rtl/core/lkv_req_if.sv
rtl/core/lkv_rsp_if.sv
rtl/core/lkv_cfg_if.sv
rtl/core/lkv_store.sv
rtl/core/lkv_ctrl.sv
rtl/core/lru_key_value_cache.sv
bench/tb.sv
